/* src/wis_pkg.sv */
// Package: shared types, command codes and widths of the weighted index selector.
package wis_pkg;

    // Default sizes of the weight table.
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed widths of the channel fields.
    localparam int CMD_W       = 2;
    localparam int WEIGHT_IN_W = 16;
    localparam int POINT_W     = 17;
    localparam int INDEX_OUT_W = 8;

    // Selection point format: 16 fraction bits, so one is 65536.
    localparam int                 POINT_FRAC_BITS = 16;
    localparam logic [POINT_W-1:0] POINT_ONE       = 17'd65536;

    // Command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Operation handed from the front to the back.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_SELECT
    } t_op;

    // One decoded word in the queue.
    typedef struct packed {
        t_op                    op;
        logic [WEIGHT_IN_W-1:0] weight;
        logic [POINT_W-1:0]     point;
    } t_work;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_RESULT
    } t_back_state;

endpackage

/* src/wis_if.sv */
// Interfaces: command channel and result channel with valid/ready handshake.
interface wis_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [wis_pkg::CMD_W-1:0]       command;
    logic [wis_pkg::WEIGHT_IN_W-1:0] weight_value;
    logic [wis_pkg::POINT_W-1:0]     select_point;

    modport source (output valid, output command, output weight_value,
                    output select_point, input ready);
    modport sink (input valid, input command, input weight_value,
                  input select_point, output ready);
endinterface

interface wis_res_if;
    logic                            valid;
    logic                            ready;
    logic [wis_pkg::INDEX_OUT_W-1:0] chosen_index;
    logic                            found;

    modport source (output valid, output chosen_index, output found, input ready);
    modport sink (input valid, input chosen_index, input found, output ready);
endinterface

/* src/wis_front.sv */
// Front end: decodes command words, saturates the point and feeds the queue.
module wis_front (
    wis_cmd_if.sink        i_cmd,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output wis_pkg::t_work o_push_item
);

    // A word is taken whenever the queue has room; unused codes are dropped.
    assign i_cmd.ready = i_push_ready;

    // Decode the command and saturate the point at one.
    always_comb begin
        o_push_item.weight = i_cmd.weight_value;
        o_push_item.point  = (i_cmd.select_point > wis_pkg::POINT_ONE) ?
                             wis_pkg::POINT_ONE : i_cmd.select_point;
        case (i_cmd.command)
            wis_pkg::CMD_CLEAR: begin
                o_push_item.op = wis_pkg::OP_CLEAR;
                o_push_valid   = i_cmd.valid;
            end
            wis_pkg::CMD_APPEND: begin
                o_push_item.op = wis_pkg::OP_APPEND;
                o_push_valid   = i_cmd.valid;
            end
            wis_pkg::CMD_SELECT: begin
                o_push_item.op = wis_pkg::OP_SELECT;
                o_push_valid   = i_cmd.valid;
            end
            default: begin
                o_push_item.op = wis_pkg::OP_CLEAR;
                o_push_valid   = 1'b0;
            end
        endcase
    end

endmodule

/* src/wis_queue.sv */
// Queue: short FIFO of decoded words between the front and the back.
module wis_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  wis_pkg::t_work i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output wis_pkg::t_work o_pop_item
);

    localparam int PTR_W  = (wis_pkg::QUEUE_DEPTH > 1) ? $clog2(wis_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(wis_pkg::QUEUE_DEPTH + 1);

    wis_pkg::t_work r_slot [wis_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              push;
    logic              pop;

    // Handshake on both sides.
    assign o_push_ready = (r_fill != FILL_W'(wis_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_item   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(wis_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(wis_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

/* src/wis_back.sv */
// Back end: weight table, running total and the cumulative selection scan.
module wis_back #(
    parameter int MAX_ENTRIES = wis_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_work_valid,
    output logic           o_work_pop,
    input  wis_pkg::t_work i_work,
    wis_res_if.source      o_res
);

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int STORE_W = (WEIGHT_BITS < wis_pkg::WEIGHT_IN_W) ?
                             WEIGHT_BITS : wis_pkg::WEIGHT_IN_W;
    localparam int TOT_W   = STORE_W + CNT_W;
    localparam int TGT_W   = TOT_W + wis_pkg::POINT_W;
    localparam int FRAC_W  = wis_pkg::POINT_FRAC_BITS;
    localparam int OUT_W   = wis_pkg::INDEX_OUT_W;

    wis_pkg::t_back_state r_state;
    wis_pkg::t_back_state n_state;

    logic [STORE_W-1:0]         r_mem [MAX_ENTRIES];
    logic [STORE_W-1:0]         r_rdata;
    logic [CNT_W-1:0]           r_count;
    logic [TOT_W-1:0]           r_total;
    logic [wis_pkg::POINT_W-1:0] r_point;
    logic [TGT_W-1:0]           r_target;
    logic [TOT_W-1:0]           r_cum;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_uniform;
    logic [IDX_W-1:0]           r_pick;
    logic                       r_found;
    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_index;
    logic                       r_out_found;

    logic [TOT_W-1:0] n_cum;
    logic [TOT_W-1:0] mul_op;
    logic [TGT_W-1:0] n_target;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic             mem_we;
    logic             full;
    logic             last;
    logic             hit;
    logic             load_out;

    // Table status and the scan arithmetic.
    assign full     = (r_count == CNT_W'(MAX_ENTRIES));
    assign last     = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign n_cum    = r_cum + (r_uniform ? TOT_W'(1) : TOT_W'(r_rdata));
    assign mul_op   = (r_total == '0) ? TOT_W'(r_count) : r_total;
    assign n_target = TGT_W'(r_point) * TGT_W'(mul_op);

    // Sequencer outputs.
    always_comb begin
        o_work_pop = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        hit        = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            wis_pkg::ST_IDLE: begin
                o_work_pop = i_work_valid;
                mem_we     = i_work_valid && (i_work.op == wis_pkg::OP_APPEND) && !full;
            end
            wis_pkg::ST_MUL: begin
                rd_en = 1'b1;
            end
            wis_pkg::ST_SCAN: begin
                hit     = (r_target <= TGT_W'({n_cum, {FRAC_W{1'b0}}})) || last;
                rd_en   = !hit;
                rd_addr = r_idx + IDX_W'(1);
            end
            wis_pkg::ST_RESULT: begin
                load_out = !r_out_valid || o_res.ready;
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            wis_pkg::ST_IDLE: begin
                if (i_work_valid && (i_work.op == wis_pkg::OP_SELECT)) begin
                    n_state = (r_count == '0) ? wis_pkg::ST_RESULT : wis_pkg::ST_MUL;
                end
            end
            wis_pkg::ST_MUL: begin
                n_state = wis_pkg::ST_SCAN;
            end
            wis_pkg::ST_SCAN: begin
                if (hit) begin
                    n_state = wis_pkg::ST_RESULT;
                end
            end
            wis_pkg::ST_RESULT: begin
                if (load_out) begin
                    n_state = wis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wis_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state: sequencer, table fill, total and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wis_pkg::ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_work_pop && (i_work.op == wis_pkg::OP_CLEAR)) begin
                r_count <= '0;
                r_total <= '0;
            end else if (mem_we) begin
                r_count <= r_count + CNT_W'(1);
                r_total <= r_total + TOT_W'(i_work.weight[STORE_W-1:0]);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Weight memory: one write port for appends, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[IDX_W-1:0]] <= i_work.weight[STORE_W-1:0];
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Selection datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            wis_pkg::ST_IDLE: begin
                r_point <= i_work.point;
                r_pick  <= '0;
                r_found <= 1'b0;
            end
            wis_pkg::ST_MUL: begin
                r_target  <= n_target;
                r_uniform <= (r_total == '0);
                r_cum     <= '0;
                r_idx     <= '0;
            end
            wis_pkg::ST_SCAN: begin
                if (hit) begin
                    r_pick  <= r_idx;
                    r_found <= 1'b1;
                end else begin
                    r_cum <= n_cum;
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            wis_pkg::ST_RESULT: begin
                if (load_out) begin
                    r_out_index <= OUT_W'(r_pick);
                    r_out_found <= r_found;
                end
            end
            default: begin
            end
        endcase
    end

    // Result channel.
    assign o_res.valid        = r_out_valid;
    assign o_res.chosen_index = r_out_index;
    assign o_res.found        = r_out_found;

    // The table never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds table capacity");

    // An empty table has a zero total.
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("empty table with nonzero total");

    // The scan only visits written entries.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wis_pkg::ST_SCAN) |-> (CNT_W'(r_idx) < r_count))
        else $error("scan index past the last entry");

    // The partial sum never passes the total before a hit.
    a_cum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == wis_pkg::ST_SCAN) && !r_uniform) |-> (r_cum <= r_total))
        else $error("cumulative weight exceeds total");

endmodule

/* src/weighted_index_selector.sv */
// Top level: roulette-wheel selector with a decoupled front end, queue and back end.
//
//   channel  | dir | handshake          | word
//   i_cmd    | in  | valid/ready        | command, weight_value, select_point
//   o_res    | out | valid/ready        | chosen_index, found
//
// Clear and append are done in the back end's idle state; a select passes through
// the multiply, scan and result states, the scan reading 1 to entry-count entries
// from the weight memory, one per cycle; an empty table skips multiply and scan.
// Reset is synchronous and empties the table; the weight memory is not cleared.
// The front end keeps taking words while the two-word queue has room, and the
// output register holds a result until it is taken, which stalls the back end.
module weighted_index_selector #(
    parameter int MAX_ENTRIES = wis_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wis_cmd_if.sink   i_cmd,
    wis_res_if.source o_res
);

    logic           push_valid;
    logic           push_ready;
    wis_pkg::t_work push_item;
    logic           work_valid;
    logic           work_pop;
    wis_pkg::t_work work_item;

    // Command decode.
    wis_front u_front (
        .i_cmd        (i_cmd),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    // Decoupling queue.
    wis_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (work_valid),
        .i_pop        (work_pop),
        .o_pop_item   (work_item)
    );

    // Table and selection engine.
    wis_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .o_work_pop   (work_pop),
        .i_work       (work_item),
        .o_res        (o_res)
    );

endmodule

/* tb/wis_checker.sv */
// Checker: watches both channels, predicts every selection and compares the results.
module wis_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    wis_cmd_if   i_cmd,
    wis_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    // One predicted result word.
    typedef struct packed {
        logic [wis_pkg::INDEX_OUT_W-1:0] index;
        logic                            found;
    } t_pick;

    // Weights are masked to the width the block keeps.
    localparam logic [wis_pkg::WEIGHT_IN_W-1:0] WEIGHT_MASK =
        wis_pkg::WEIGHT_IN_W'((32'd1 << wis_pkg::WEIGHT_BITS_DEF) - 32'd1);

    // Private copy of the wheel: stored weights, their count and their sum.
    logic [wis_pkg::WEIGHT_IN_W-1:0] wheel_weight [wis_pkg::MAX_ENTRIES_DEF];
    logic [8:0]                      wheel_count;
    logic [23:0]                     wheel_total;
    logic [wis_pkg::WEIGHT_IN_W-1:0] new_weight;

    t_pick pending_picks [$];
    t_pick got_pick;
    t_pick want_pick;
    int    fails;

    // Spin the wheel: first entry whose cumulative weight reaches point * total.
    function automatic t_pick roll_wheel(input logic [wis_pkg::POINT_W-1:0] raw_point);
        logic [wis_pkg::POINT_W-1:0] point;
        logic [47:0]                 target;
        logic [47:0]                 cum;
        int                          pick;
        logic                        hit;
        t_pick                       r;
        r.index = '0;
        r.found = 1'b0;
        if (wheel_count == 0) begin
            return r;
        end
        point = (raw_point > wis_pkg::POINT_ONE) ? wis_pkg::POINT_ONE : raw_point;
        pick  = int'(wheel_count) - 1;
        hit   = 1'b0;
        cum   = '0;
        if (wheel_total == 0) begin
            // Zero total: every entry counts as equally likely.
            target = 48'(point) * 48'(wheel_count);
            for (int i = 0; i < int'(wheel_count); i++) begin
                if (!hit && target <= (48'(i + 1) << wis_pkg::POINT_FRAC_BITS)) begin
                    pick = i;
                    hit  = 1'b1;
                end
            end
        end else begin
            target = 48'(point) * 48'(wheel_total);
            for (int i = 0; i < int'(wheel_count); i++) begin
                cum = cum + 48'(wheel_weight[i]);
                if (!hit && target <= (cum << wis_pkg::POINT_FRAC_BITS)) begin
                    pick = i;
                    hit  = 1'b1;
                end
            end
        end
        r.index = pick[wis_pkg::INDEX_OUT_W-1:0];
        r.found = 1'b1;
        return r;
    endfunction

    // Track the wheel on every accepted command word and check every result word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wheel_count = '0;
            wheel_total = '0;
            pending_picks.delete();
            fails = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got_pick.index = i_res.chosen_index;
                got_pick.found = i_res.found;
                if (pending_picks.size() == 0) begin
                    $error("result word with no selection waiting: chosen_index %0d, found %0d",
                           got_pick.index, got_pick.found);
                    fails++;
                end else begin
                    want_pick = pending_picks.pop_front();
                    if (got_pick.index !== want_pick.index) begin
                        $error("chosen_index: expected %0d, actual %0d",
                               want_pick.index, got_pick.index);
                        fails++;
                    end
                    if (got_pick.found !== want_pick.found) begin
                        $error("found: expected %0d, actual %0d",
                               want_pick.found, got_pick.found);
                        fails++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.command)
                    wis_pkg::CMD_CLEAR: begin
                        wheel_count = '0;
                        wheel_total = '0;
                    end
                    wis_pkg::CMD_APPEND: begin
                        // A full wheel drops the weight.
                        if (int'(wheel_count) < wis_pkg::MAX_ENTRIES_DEF) begin
                            new_weight = i_cmd.weight_value & WEIGHT_MASK;
                            wheel_weight[wheel_count[7:0]] = new_weight;
                            wheel_count = wheel_count + 9'd1;
                            wheel_total = wheel_total + 24'(new_weight);
                        end
                    end
                    wis_pkg::CMD_SELECT: begin
                        pending_picks.push_back(roll_wheel(i_cmd.select_point));
                    end
                    default: begin
                        // The spare code leaves the wheel untouched.
                    end
                endcase
            end
        end
        o_pending    <= pending_picks.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/tb.sv */
// Testbench top: clock, reset, command stimulus, result back-pressure and the verdict.
module tb;

    localparam logic [wis_pkg::CMD_W-1:0] CMD_SPARE   = 2'd3;
    localparam int                        ITEM_TARGET = 750;
    localparam int                        HOLD_CYCLES = 400;
    localparam int                        TAIL_CYCLES = 600;

    // Receiver back-pressure styles.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   burst_left;
    int   item_count;
    logic hold_req;
    logic hold_done;

    wis_cmd_if cmd_ch ();
    wis_res_if res_ch ();

    weighted_index_selector uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    wis_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with a period of ten.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offer one command word, opening a new burst after a random gap when due.
    task automatic send_word(input logic [wis_pkg::CMD_W-1:0]       cmd,
                             input logic [wis_pkg::WEIGHT_IN_W-1:0] w,
                             input logic [wis_pkg::POINT_W-1:0]     p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= cmd;
        cmd_ch.weight_value <= w;
        cmd_ch.select_point <= p;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        burst_left--;
        if (cmd != CMD_SPARE) item_count++;
    endtask

    // Stop offering words until every predicted result has been taken.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Weights lean on the extremes and on small values.
    function automatic logic [wis_pkg::WEIGHT_IN_W-1:0] draw_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return wis_pkg::WEIGHT_IN_W'($urandom_range(1, 15));
            default: return wis_pkg::WEIGHT_IN_W'($urandom);
        endcase
    endfunction

    // Points cover zero, one, saturation and the whole 17-bit range.
    function automatic logic [wis_pkg::POINT_W-1:0] draw_point();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return wis_pkg::POINT_ONE;
            2:       return wis_pkg::POINT_W'($urandom_range(65537, 131071));
            3:       return wis_pkg::POINT_W'($urandom);
            default: return wis_pkg::POINT_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Receiver: changes its stall style now and then, and holds off once on request.
    initial begin
        t_rx_mode mode;
        int       mode_left;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   res_ch.ready <= 1'b1;
                    RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                    default:   res_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int   n;
        int   m;
        int   kind;
        logic zero_wheel;
        logic hold_sent;
        logic hold_now;
        logic full_sent;
        i_rst_n             <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= wis_pkg::CMD_CLEAR;
        cmd_ch.weight_value <= '0;
        cmd_ch.select_point <= '0;
        hold_req            <= 1'b0;
        burst_left = 0;
        item_count = 0;
        hold_sent  = 1'b0;
        hold_now   = 1'b0;
        full_sent  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty wheel, all-zero weights, extreme weights and points.
        send_word(wis_pkg::CMD_SELECT, '0, '0);
        send_word(wis_pkg::CMD_SELECT, '0, wis_pkg::POINT_ONE);
        send_word(wis_pkg::CMD_APPEND, '0, '0);
        send_word(wis_pkg::CMD_APPEND, '0, '0);
        send_word(wis_pkg::CMD_SELECT, '0, '0);
        send_word(wis_pkg::CMD_SELECT, '0, 17'd32768);
        send_word(wis_pkg::CMD_SELECT, '0, wis_pkg::POINT_ONE);
        send_word(wis_pkg::CMD_SELECT, '0, '1);
        send_word(wis_pkg::CMD_CLEAR, '1, '1);
        send_word(wis_pkg::CMD_SELECT, '0, 17'd40000);
        send_word(wis_pkg::CMD_APPEND, '1, '0);
        send_word(wis_pkg::CMD_APPEND, 16'd1, '0);
        send_word(wis_pkg::CMD_APPEND, '0, '0);
        send_word(CMD_SPARE, '1, '1);
        send_word(wis_pkg::CMD_SELECT, '0, '0);
        send_word(wis_pkg::CMD_SELECT, '0, 17'd1);
        send_word(wis_pkg::CMD_SELECT, '0, 17'd65535);
        send_word(wis_pkg::CMD_SELECT, '0, wis_pkg::POINT_ONE);
        send_word(wis_pkg::CMD_SELECT, '0, 17'd100000);
        send_word(CMD_SPARE, '0, '0);
        send_word(wis_pkg::CMD_CLEAR, '0, '0);
        drain();

        // Random: mostly whole clear/append/select sequences, some noise.
        while (item_count < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (!full_sent && item_count >= 350) begin
                // Fill the wheel past capacity with the largest weights.
                full_sent = 1'b1;
                send_word(wis_pkg::CMD_CLEAR, '0, '0);
                for (int i = 0; i < wis_pkg::MAX_ENTRIES_DEF + 2; i++) begin
                    send_word(wis_pkg::CMD_APPEND, '1, draw_point());
                end
                send_word(wis_pkg::CMD_SELECT, '0, '0);
                send_word(wis_pkg::CMD_SELECT, '0, wis_pkg::POINT_ONE);
                send_word(wis_pkg::CMD_SELECT, '0, '1);
                for (int i = 0; i < 5; i++) begin
                    send_word(wis_pkg::CMD_SELECT, draw_weight(), draw_point());
                end
                drain();
            end else if (kind == 0) begin
                // Noise: any code, any fields, on whatever the wheel holds.
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    send_word(wis_pkg::CMD_W'($urandom_range(0, 3)),
                              wis_pkg::WEIGHT_IN_W'($urandom), wis_pkg::POINT_W'($urandom));
                end
            end else begin
                hold_now = 1'b0;
                if (!hold_sent && item_count >= 150) begin
                    // The receiver holds off while selections keep coming.
                    hold_sent = 1'b1;
                    hold_now  = 1'b1;
                    hold_req <= 1'b1;
                end
                zero_wheel = ($urandom_range(0, 5) == 0);
                n = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
                m = hold_now ? 12 : $urandom_range(1, 8);
                send_word(wis_pkg::CMD_CLEAR, wis_pkg::WEIGHT_IN_W'($urandom),
                          wis_pkg::POINT_W'($urandom));
                for (int i = 0; i < n; i++) begin
                    send_word(wis_pkg::CMD_APPEND, zero_wheel ? '0 : draw_weight(),
                              wis_pkg::POINT_W'($urandom));
                    if ($urandom_range(0, 15) == 0) begin
                        send_word(CMD_SPARE, wis_pkg::WEIGHT_IN_W'($urandom),
                                  wis_pkg::POINT_W'($urandom));
                    end
                end
                for (int i = 0; i < m; i++) begin
                    send_word(wis_pkg::CMD_SELECT, wis_pkg::WEIGHT_IN_W'($urandom),
                              draw_point());
                end
                hold_req <= 1'b0;
                if (kind == 9) drain();
            end
        end

        // Let every result come, then allow the back end time to settle.
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10000000;
        $display("tb: failure");
        $finish;
    end

endmodule
